// ===== rtl/core/gmpd_pkg.sv =====
// Shared types and constants for the gated multi-press gesture detector.
package gmpd_pkg;

  localparam int unsigned TimeBitsDefault = 32;

  localparam int unsigned CountBits  = 4;
  localparam int unsigned MsCfgBits  = 16;
  localparam int unsigned CfgIdxBits = 2;
  localparam int unsigned CfgDataBits = 16;

  localparam logic [MsCfgBits-1:0] ResetPressWindowMs = 16'd2000;
  localparam logic [CountBits-1:0] ResetPressTarget   = 4'd3;
  localparam logic [MsCfgBits-1:0] ResetRequestHoldMs = 16'd600;

  typedef enum logic [CfgIdxBits-1:0] {
    CfgPressWindow = 2'd0,
    CfgPressTarget = 2'd1,
    CfgRequestHold = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [MsCfgBits-1:0] press_window_ms;
    logic [CountBits-1:0] press_target;
    logic [MsCfgBits-1:0] request_hold_ms;
  } cfg_t;

  typedef struct packed {
    logic                 calibration_request;
    logic                 raw_or_held_request;
    logic                 toggle_seen;
    logic                 gate_blocked;
    logic [CountBits-1:0] presses_so_far;
  } result_t;

endpackage

// ===== rtl/core/gmpd_cfg_regs.sv =====
// Configuration register file for the gesture detector.
module gmpd_cfg_regs (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  input  logic [gmpd_pkg::CfgIdxBits-1:0]      cfg_index_i,
  input  logic [gmpd_pkg::CfgDataBits-1:0]     cfg_data_i,
  output gmpd_pkg::cfg_t                       cfg_o
);

  gmpd_pkg::cfg_t cfg_q;
  gmpd_pkg::cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (gmpd_pkg::cfg_idx_e'(cfg_index_i))
        gmpd_pkg::CfgPressWindow:
          cfg_d.press_window_ms = cfg_data_i[gmpd_pkg::MsCfgBits-1:0];
        gmpd_pkg::CfgPressTarget:
          cfg_d.press_target = cfg_data_i[gmpd_pkg::CountBits-1:0];
        gmpd_pkg::CfgRequestHold:
          cfg_d.request_hold_ms = cfg_data_i[gmpd_pkg::MsCfgBits-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.press_window_ms <= gmpd_pkg::ResetPressWindowMs;
      cfg_q.press_target    <= gmpd_pkg::ResetPressTarget;
      cfg_q.request_hold_ms <= gmpd_pkg::ResetRequestHoldMs;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/core/gmpd_core.sv =====
// Gesture state registers and the single-pass per-tick update logic.
module gmpd_core #(
  parameter int unsigned TimeBits = gmpd_pkg::TimeBitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [TimeBits-1:0] time_ms_i,
  input  logic                button_toggled_i,
  input  logic                gate_open_i,
  input  gmpd_pkg::cfg_t      cfg_i,
  output gmpd_pkg::result_t   result_o
);

  localparam int unsigned CB = gmpd_pkg::CountBits;

  logic [CB-1:0]       press_count_q, press_count_d;
  logic [TimeBits-1:0] window_start_q, window_start_d;
  logic [TimeBits-1:0] last_req_q, last_req_d;
  logic                baseline_q, baseline_d;
  logic                req_valid_q, req_valid_d;

  logic [TimeBits-1:0] window_elapsed;
  logic [TimeBits-1:0] hold_elapsed;
  logic [CB-1:0]       count_base;
  logic [CB-1:0]       count_inc;
  logic                window_expired;
  logic                raw;
  logic                seen;
  logic                hold;

  assign window_elapsed = time_ms_i - window_start_q;
  assign window_expired = window_elapsed > TimeBits'(cfg_i.press_window_ms);

  // A count that was zero or whose window ran out starts over from this press.
  assign count_base = (press_count_q == '0 || window_expired) ? '0 : press_count_q;
  assign count_inc  = count_base + CB'(1);

  always_comb begin
    press_count_d  = press_count_q;
    window_start_d = window_start_q;
    last_req_d     = last_req_q;
    baseline_d     = baseline_q;
    req_valid_d    = req_valid_q;
    raw            = 1'b0;
    seen           = 1'b0;
    priority if (!gate_open_i) begin
      press_count_d  = '0;
      window_start_d = time_ms_i;
      last_req_d     = '0;
      req_valid_d    = 1'b0;
      baseline_d     = 1'b0;
    end else if (!baseline_q) begin
      baseline_d     = 1'b1;
      press_count_d  = '0;
      window_start_d = time_ms_i;
    end else if (button_toggled_i) begin
      seen          = 1'b1;
      press_count_d = count_inc;
      if (count_base == '0) begin
        window_start_d = time_ms_i;
      end
      if (count_inc >= cfg_i.press_target) begin
        press_count_d  = '0;
        window_start_d = time_ms_i;
        last_req_d     = time_ms_i;
        req_valid_d    = 1'b1;
        raw            = 1'b1;
      end
    end
  end

  assign hold_elapsed = time_ms_i - last_req_d;
  assign hold = req_valid_d && (hold_elapsed <= TimeBits'(cfg_i.request_hold_ms));

  always_comb begin
    result_o.calibration_request = hold && gate_open_i;
    result_o.raw_or_held_request = raw || hold;
    result_o.toggle_seen         = seen;
    result_o.gate_blocked        = !gate_open_i;
    result_o.presses_so_far      = press_count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      press_count_q  <= '0;
      window_start_q <= '0;
      last_req_q     <= '0;
      baseline_q     <= 1'b0;
      req_valid_q    <= 1'b0;
    end else if (step_i) begin
      press_count_q  <= press_count_d;
      window_start_q <= window_start_d;
      last_req_q     <= last_req_d;
      baseline_q     <= baseline_d;
      req_valid_q    <= req_valid_d;
    end
  end

endmodule

// ===== rtl/core/gated_multi_press_gesture_detector_unit.sv =====
// Top level of the gated multi-press gesture detector.
//
// Usage: each input word is one control tick (timestamp, button toggle flag,
// gate flag). The input channel is accepted when in_valid_i is high and
// in_stall_o is low; the output channel hands over one result word per input
// word when out_valid_o is high and out_stall_i is low.
// The tick is captured in an input register, evaluated against the gesture
// state in one pass, and its result is captured in an output register, where
// the result word becomes valid. Throughput is one word per cycle while the
// receiver does not stall, limited only by the single update of the gesture
// state. When the receiver stalls, the output register holds its word; the
// input register still drains into it when it frees, and in_stall_o rises
// only once both registers are full.
// Configuration writes use cfg_valid_i/cfg_ready_o (always ready), index 0 is
// the press window, 1 the press target, 2 the hold time; other indexes are
// ignored. Reset clears the gesture state, loads the register defaults and
// empties both registers.
module gated_multi_press_gesture_detector_unit #(
  parameter int unsigned TimeBits = gmpd_pkg::TimeBitsDefault
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [TimeBits-1:0]                  time_ms_i,
  input  logic                                 button_toggled_i,
  input  logic                                 gate_open_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 calibration_request_o,
  output logic                                 raw_or_held_request_o,
  output logic                                 toggle_seen_o,
  output logic                                 gate_blocked_o,
  output logic [gmpd_pkg::CountBits-1:0]       presses_so_far_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [gmpd_pkg::CfgIdxBits-1:0]      cfg_index_i,
  input  logic [gmpd_pkg::CfgDataBits-1:0]     cfg_data_i
);

  gmpd_pkg::cfg_t    cfg;
  gmpd_pkg::result_t result;

  logic                in_valid_q;
  logic [TimeBits-1:0] time_q;
  logic                toggled_q;
  logic                gate_q;
  logic                out_valid_q;
  gmpd_pkg::result_t   out_q;
  logic                step;
  logic                in_load;

  assign cfg_ready_o = 1'b1;

  gmpd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // The held tick moves on whenever the output register is empty or being taken.
  assign step       = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !step;
  assign in_load    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_load || step) begin
      in_valid_q <= in_load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      time_q    <= time_ms_i;
      toggled_q <= button_toggled_i;
      gate_q    <= gate_open_i;
    end
  end

  gmpd_core #(
    .TimeBits (TimeBits)
  ) u_core (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .step_i           (step),
    .time_ms_i        (time_q),
    .button_toggled_i (toggled_q),
    .gate_open_i      (gate_q),
    .cfg_i            (cfg),
    .result_o         (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= result;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign calibration_request_o = out_q.calibration_request;
  assign raw_or_held_request_o = out_q.raw_or_held_request;
  assign toggle_seen_o         = out_q.toggle_seen;
  assign gate_blocked_o        = out_q.gate_blocked;
  assign presses_so_far_o      = out_q.presses_so_far;

endmodule

// ===== tb/gated_multi_press_gesture_detector_unit_test.sv =====
// Self-checking testbench for the gated multi-press gesture detector unit.
`timescale 1ns / 1ps

module gated_multi_press_gesture_detector_unit_test;

  localparam int unsigned StampBits = 32;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainCycles = 4;
  // Index 3 has no register behind it; writes to it must be ignored.
  localparam logic [gmpd_pkg::CfgIdxBits-1:0] CfgSpareIdx = 2'd3;

  typedef struct packed {
    logic [StampBits-1:0] stamp;
    logic                 toggled;
    logic                 gate;
  } tick_t;

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             in_valid_i = 1'b0;
  logic                             in_stall_o;
  logic [StampBits-1:0]             time_ms_i = '0;
  logic                             button_toggled_i = 1'b0;
  logic                             gate_open_i = 1'b0;
  logic                             out_valid_o;
  logic                             out_stall_i = 1'b0;
  logic                             calibration_request_o;
  logic                             raw_or_held_request_o;
  logic                             toggle_seen_o;
  logic                             gate_blocked_o;
  logic [gmpd_pkg::CountBits-1:0]   presses_so_far_o;
  logic                             cfg_valid_i = 1'b0;
  logic                             cfg_ready_o;
  logic [gmpd_pkg::CfgIdxBits-1:0]  cfg_index_i = '0;
  logic [gmpd_pkg::CfgDataBits-1:0] cfg_data_i = '0;

  gated_multi_press_gesture_detector_unit #(
    .TimeBits(StampBits)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .time_ms_i(time_ms_i),
    .button_toggled_i(button_toggled_i),
    .gate_open_i(gate_open_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .calibration_request_o(calibration_request_o),
    .raw_or_held_request_o(raw_or_held_request_o),
    .toggle_seen_o(toggle_seen_o),
    .gate_blocked_o(gate_blocked_o),
    .presses_so_far_o(presses_so_far_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i)
  );

  // Configuration as the detector should currently hold it.
  logic [gmpd_pkg::MsCfgBits-1:0] cfg_window = gmpd_pkg::ResetPressWindowMs;
  logic [gmpd_pkg::CountBits-1:0] cfg_target = gmpd_pkg::ResetPressTarget;
  logic [gmpd_pkg::MsCfgBits-1:0] cfg_hold = gmpd_pkg::ResetRequestHoldMs;

  // Gesture state mirrored from the detector.
  logic [gmpd_pkg::CountBits-1:0] g_count = '0;
  logic [StampBits-1:0] g_window_start = '0;
  logic [StampBits-1:0] g_request_stamp = '0;
  logic                 g_baseline = 1'b0;
  logic                 g_request_valid = 1'b0;

  tick_t             tick_backlog[$];
  gmpd_pkg::result_t pending_results[$];
  tick_t             offered;

  logic [StampBits-1:0] stamp_now = '0;
  bit idle_on = 1'b0;
  bit choke_done = 1'b0;
  int send_gap = 0;
  int stall_left = 0;
  int choke_left = 0;
  int ticks_accepted = 0;
  int results_checked = 0;
  int requests_seen = 0;
  int blocked_seen = 0;
  int mismatches = 0;
  int cycle_count = 0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
               pending_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Advances the mirrored gesture state by one tick and queues its result.
  task automatic track_gesture(input tick_t t);
    gmpd_pkg::result_t r;
    logic [StampBits-1:0] since;
    logic raw;
    logic hold;
    r = '0;
    raw = 1'b0;
    if (!t.gate) begin
      g_count = '0;
      g_window_start = t.stamp;
      g_request_stamp = '0;
      g_request_valid = 1'b0;
      g_baseline = 1'b0;
      r.gate_blocked = 1'b1;
    end else if (!g_baseline) begin
      g_baseline = 1'b1;
      g_count = '0;
      g_window_start = t.stamp;
    end else if (t.toggled) begin
      r.toggle_seen = 1'b1;
      since = t.stamp - g_window_start;
      if (g_count == '0 || since > {16'h0000, cfg_window}) begin
        g_count = '0;
        g_window_start = t.stamp;
      end
      g_count = g_count + 1'b1;
      if (g_count >= cfg_target) begin
        g_count = '0;
        g_window_start = t.stamp;
        g_request_stamp = t.stamp;
        g_request_valid = 1'b1;
        raw = 1'b1;
      end
    end
    since = t.stamp - g_request_stamp;
    hold = g_request_valid && (since <= {16'h0000, cfg_hold});
    r.calibration_request = hold && t.gate;
    r.raw_or_held_request = raw || hold;
    r.presses_so_far = g_count;
    pending_results.push_back(r);
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        track_gesture(offered);
        ticks_accepted <= ticks_accepted + 1;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (tick_backlog.size() != 0) begin
          offered = tick_backlog.pop_front();
          in_valid_i <= 1'b1;
          time_ms_i <= offered.stamp;
          button_toggled_i <= offered.toggled;
          gate_open_i <= offered.gate;
          if (idle_on && $urandom_range(0, 7) == 0) begin
            send_gap = $urandom_range(1, 15);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver stalls: short random bursts, plus one long hold-off that backs
  // the detector up until it stalls its own input.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (choke_left > 0) begin
      out_stall_i <= 1'b1;
      choke_left <= choke_left - 1;
    end else if (!choke_done && ticks_accepted >= 150) begin
      out_stall_i <= 1'b1;
      choke_left <= 80;
      choke_done <= 1'b1;
    end else if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      out_stall_i <= 1'b1;
      stall_left <= $urandom_range(0, 14);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  function automatic void check_field(string what, logic [3:0] want, logic [3:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    gmpd_pkg::result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result word with none expected, got presses %0d", $time,
                 presses_so_far_o);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("calibration_request", 4'(want.calibration_request),
                    4'(calibration_request_o));
        check_field("raw_or_held_request", 4'(want.raw_or_held_request),
                    4'(raw_or_held_request_o));
        check_field("toggle_seen", 4'(want.toggle_seen), 4'(toggle_seen_o));
        check_field("gate_blocked", 4'(want.gate_blocked), 4'(gate_blocked_o));
        check_field("presses_so_far", want.presses_so_far, presses_so_far_o);
        results_checked++;
        if (want.raw_or_held_request) requests_seen++;
        if (want.gate_blocked) blocked_seen++;
      end
    end
  end

  task automatic write_reg(input logic [gmpd_pkg::CfgIdxBits-1:0] idx,
                           input logic [gmpd_pkg::CfgDataBits-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      gmpd_pkg::CfgPressWindow: cfg_window = data;
      gmpd_pkg::CfgPressTarget: cfg_target = data[gmpd_pkg::CountBits-1:0];
      gmpd_pkg::CfgRequestHold: cfg_hold = data;
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic queue_tick(input logic [StampBits-1:0] stamp, input logic toggled,
                            input logic gate);
    tick_t t;
    t.stamp = stamp;
    t.toggled = toggled;
    t.gate = gate;
    tick_backlog.push_back(t);
  endtask

  // Gap between ticks, landing on or just past a window boundary now and then.
  function automatic logic [StampBits-1:0] pick_gap(input logic [StampBits-1:0] span);
    case ($urandom_range(0, 5))
      0: return '0;
      1: return span;
      2: return span + 1;
      default: return $urandom_range(0, span);
    endcase
  endfunction

  // Mostly complete gestures with random spacing, followed by a probe of the
  // hold window; the rest is closed-gate spells, time jumps and quiet ticks.
  task automatic queue_gestures(input int n);
    int made;
    int kind;
    int presses;
    logic [StampBits-1:0] span;
    made = 0;
    while (made < n) begin
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
        if (cfg_target == '0) begin
          presses = $urandom_range(1, 3);
          span = cfg_window;
        end else begin
          presses = ($urandom_range(0, 3) != 0) ? cfg_target : $urandom_range(1, cfg_target);
          span = cfg_window / cfg_target;
        end
        for (int i = 0; i < presses; i++) begin
          if ($urandom_range(0, 4) == 0) begin
            stamp_now = stamp_now + $urandom_range(0, span);
            queue_tick(stamp_now, 1'b0, 1'b1);
            made++;
          end
          stamp_now = stamp_now + pick_gap(span);
          queue_tick(stamp_now, 1'b1, 1'b1);
          made++;
        end
        stamp_now = stamp_now + pick_gap(cfg_hold);
        queue_tick(stamp_now, 1'b0, 1'b1);
        made++;
      end else if (kind == 7) begin
        repeat ($urandom_range(1, 3)) begin
          stamp_now = stamp_now + $urandom_range(0, 50);
          queue_tick(stamp_now, $urandom_range(0, 1), 1'b0);
          made++;
        end
        stamp_now = stamp_now + $urandom_range(0, 50);
        queue_tick(stamp_now, $urandom_range(0, 1), 1'b1);
        made++;
      end else if (kind == 8) begin
        stamp_now = $urandom();
        queue_tick(stamp_now, $urandom_range(0, 1), $urandom_range(0, 1));
        made++;
      end else begin
        stamp_now = stamp_now + $urandom_range(0, cfg_window + cfg_hold + 2);
        queue_tick(stamp_now, 1'b0, 1'b1);
        made++;
      end
    end
  endtask

  task automatic settle();
    do @(negedge clk_i);
    while (tick_backlog.size() != 0 || in_valid_i || pending_results.size() != 0);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    idle_on = 1'b1;

    // Power-on settings: closed gate first, a baseline that ignores its
    // toggle, a gesture completing exactly at time zero after a wrap, the
    // hold edge, the press window edge and a gate closing mid-hold.
    queue_tick(32'hFFFF_FFFF, 1'b1, 1'b0);
    queue_tick(32'hFFFF_FFF0, 1'b1, 1'b1);
    queue_tick(32'hFFFF_FFF8, 1'b1, 1'b1);
    queue_tick(32'hFFFF_FFFC, 1'b0, 1'b1);
    queue_tick(32'hFFFF_FFFE, 1'b1, 1'b1);
    queue_tick(32'h0000_0000, 1'b1, 1'b1);
    queue_tick(32'd600, 1'b0, 1'b1);
    queue_tick(32'd601, 1'b0, 1'b1);
    queue_tick(32'd4096, 1'b1, 1'b1);
    queue_tick(32'd6096, 1'b1, 1'b1);
    queue_tick(32'd6097, 1'b1, 1'b1);
    queue_tick(32'd6102, 1'b1, 1'b1);
    queue_tick(32'd6107, 1'b1, 1'b1);
    queue_tick(32'd6110, 1'b1, 1'b0);
    queue_tick(32'd6111, 1'b0, 1'b1);
    queue_tick(32'h5555_5555, 1'b1, 1'b1);
    queue_tick(32'hAAAA_AAAA, 1'b1, 1'b1);
    queue_tick(32'hAAAA_AAAA, 1'b1, 1'b1);
    queue_tick(32'hAAAA_AAAA, 1'b1, 1'b1);
    queue_tick(32'hAAAA_AAAA, 1'b0, 1'b1);
    queue_tick(32'h5555_5555, 1'b0, 1'b0);
    queue_tick(32'h5555_5555, 1'b0, 1'b1);
    settle();

    write_reg(CfgSpareIdx, 16'($urandom()));
    write_reg(gmpd_pkg::CfgPressWindow, 16'h0000);
    write_reg(gmpd_pkg::CfgPressTarget, 16'hFFF1);
    write_reg(gmpd_pkg::CfgRequestHold, 16'h0000);
    queue_gestures(100);
    settle();

    write_reg(gmpd_pkg::CfgPressWindow, 16'hFFFF);
    write_reg(gmpd_pkg::CfgPressTarget, 16'hFFFF);
    write_reg(gmpd_pkg::CfgRequestHold, 16'hFFFF);
    queue_gestures(100);
    settle();

    // A target of zero lets every counted toggle finish a gesture.
    idle_on = 1'b0;
    write_reg(gmpd_pkg::CfgPressWindow, 16'd300);
    write_reg(gmpd_pkg::CfgPressTarget, 16'hABC0);
    write_reg(gmpd_pkg::CfgRequestHold, 16'd100);
    queue_gestures(100);
    settle();

    idle_on = 1'b1;
    write_reg(gmpd_pkg::CfgPressWindow, 16'd50);
    write_reg(gmpd_pkg::CfgPressTarget, 16'd4);
    write_reg(gmpd_pkg::CfgRequestHold, 16'd20);
    write_reg(CfgSpareIdx, 16'($urandom()));
    queue_gestures(100);
    settle();

    idle_on = 1'b0;
    write_reg(gmpd_pkg::CfgPressWindow, 16'($urandom_range(0, 65535)));
    write_reg(gmpd_pkg::CfgPressTarget,
              {12'($urandom_range(0, 4095)), 4'($urandom_range(1, 15))});
    write_reg(gmpd_pkg::CfgRequestHold, 16'($urandom_range(0, 65535)));
    queue_gestures(100);
    settle();
    repeat (8) @(negedge clk_i);

    $display("Checked %0d results from %0d ticks across six register settings.",
             results_checked, ticks_accepted);
    $display("Saw %0d request ticks and %0d blocked ticks; %0d mismatches.",
             requests_seen, blocked_seen, mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
